// ===== sv/terminal_text_cleaner_unit_defines.svh =====
// assertion helpers for the rtl controller (tcc_ctrl)
// expects clk and rst_n in the scope of use
`ifndef TERMINAL_TEXT_CLEANER_UNIT_DEFINES_SVH
`define TERMINAL_TEXT_CLEANER_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcc_pkg.sv =====
`default_nettype none

package tcc_pkg;

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 12;
  localparam int LEN_W    = 13;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [BYTE_W-1:0] CH_BEL   = 8'h07;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_BSLSH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_RBRK  = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CSI_LO   = 8'h40;
  localparam logic [BYTE_W-1:0] CSI_HI   = 8'h7E;
  localparam logic [1:0]        UTF8_CONT_TAG = 2'b10;

  // escape parser states
  typedef enum logic [2:0] {
    ES_GROUND  = 3'd0,
    ES_ESC     = 3'd1,
    ES_CSI     = 3'd2,
    ES_OSC     = 3'd3,
    ES_OSC_ESC = 3'd4
  } esc_t;

  // store port strobes from the controller
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== sv/tcc_if.sv =====
`default_nettype none

interface tcc_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcc_pkg::OP_W-1:0]     op;
  logic [tcc_pkg::BYTE_W-1:0]   in_byte;
  logic [tcc_pkg::IDX_W-1:0]    read_index;

  modport source (output valid, op, in_byte, read_index, input ready);
  modport sink   (input valid, op, in_byte, read_index, output ready);
endinterface

interface tcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcc_pkg::LEN_W-1:0]    text_length;
  logic                         overflowed;
  logic [tcc_pkg::BYTE_W-1:0]   out_byte;
  logic                         index_ok;

  modport source (output valid, text_length, overflowed, out_byte, index_ok, input ready);
  modport sink   (input valid, text_length, overflowed, out_byte, index_ok, output ready);
endinterface

`default_nettype wire

// ===== sv/tcc_store.sv =====
`default_nettype none

module tcc_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                       clk,
  input  wire tcc_pkg::mem_ctl_t          ctl,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [tcc_pkg::BYTE_W-1:0] wr_data,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [tcc_pkg::BYTE_W-1:0] rd_data
);
  import tcc_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data held until the next read strobe
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/tcc_ctrl.sv =====
`default_nettype none

module tcc_ctrl #(
  parameter int STORE_DEPTH = 4096,
  parameter int AW          = 12,
  parameter int CW          = 13
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tcc_in_if.sink                          in_ch,
  tcc_out_if.source                       out_ch,
  output tcc_pkg::mem_ctl_t               mem_ctl,
  output logic      [AW-1:0]              wr_addr,
  output logic      [tcc_pkg::BYTE_W-1:0] wr_data,
  output logic      [AW-1:0]              rd_addr,
  input  wire logic [tcc_pkg::BYTE_W-1:0] rd_data
);
  import tcc_pkg::*;

  `include "terminal_text_cleaner_unit_defines.svh"

  localparam int IW = (AW > IDX_W) ? AW : IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BS,
    S_RES
  } state_t;

  state_t            state_r, state_nxt;
  esc_t              esc_r, esc_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              fin_r, fin_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [LEN_W-1:0]  res_len_r, res_len_nxt;
  logic              res_ovf_r, res_ovf_nxt;
  logic              res_ok_r, res_ok_nxt;

  logic              accept;
  logic              out_free;
  esc_t              esc_e;
  logic [CW-1:0]     cnt_e;
  logic              ovf_e;
  logic [CW-1:0]     cnt_dec;
  logic [CW-1:0]     bs_prev;
  logic [IW-1:0]     idx_ext;
  logic [LEN_W-1:0]  len_sat;
  logic              idx_ok;
  logic [BYTE_W-1:0] b;
  logic              do_store;
  logic              do_bs;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign b           = in_ch.in_byte;

  // a push after finish starts a fresh text
  assign esc_e   = fin_r ? ES_GROUND : esc_r;
  assign cnt_e   = fin_r ? '0 : count_r;
  assign ovf_e   = fin_r ? 1'b0 : ovf_r;
  assign cnt_dec = cnt_e - CW'(1);
  assign bs_prev = count_r - CW'(1);

  assign idx_ext = IW'(in_ch.read_index);
  assign idx_ok  = 32'(in_ch.read_index) < 32'(count_r);
  assign len_sat = (32'(count_r) > 32'(LEN_MAX)) ? LEN_MAX : LEN_W'(count_r);

  always_comb begin
    state_nxt     = state_r;
    esc_nxt       = esc_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;
    out_byte_nxt  = out_byte_r;
    out_ok_nxt    = out_ok_r;
    res_len_nxt   = res_len_r;
    res_ovf_nxt   = res_ovf_r;
    res_ok_nxt    = res_ok_r;
    mem_ctl       = '0;
    wr_addr       = cnt_e[AW-1:0];
    wr_data       = b;
    rd_addr       = idx_ext[AW-1:0];
    do_store      = 1'b0;
    do_bs         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.op)
            OP_PUSH: begin
              esc_nxt   = esc_e;
              count_nxt = cnt_e;
              ovf_nxt   = ovf_e;
              fin_nxt   = 1'b0;
              case (esc_e)
                ES_ESC: begin
                  if (b == CH_LBRK) begin
                    esc_nxt = ES_CSI;
                  end else if (b == CH_RBRK) begin
                    esc_nxt = ES_OSC;
                  end else begin
                    esc_nxt = ES_GROUND;
                  end
                end
                ES_CSI: begin
                  if (b >= CSI_LO && b <= CSI_HI) begin
                    esc_nxt = ES_GROUND;
                  end
                end
                ES_OSC, ES_OSC_ESC: begin
                  if (b == CH_BEL) begin
                    esc_nxt = ES_GROUND;
                  end else if (esc_e == ES_OSC_ESC && b == CH_BSLSH) begin
                    esc_nxt = ES_GROUND;
                  end else if (b == CH_ESC) begin
                    esc_nxt = ES_OSC_ESC;
                  end else begin
                    esc_nxt = ES_OSC;
                  end
                end
                default: begin
                  esc_nxt = ES_GROUND;
                  if (b == CH_ESC) begin
                    esc_nxt = ES_ESC;
                  end else if (b == CH_BS) begin
                    do_bs = 1'b1;
                  end else if (b == CH_LF || b == CH_TAB) begin
                    do_store = 1'b1;
                  end else if (b < CH_SPACE || b == CH_DEL) begin
                    do_store = 1'b0;
                  end else begin
                    do_store = 1'b1;
                  end
                end
              endcase
              if (do_store) begin
                if (32'(cnt_e) < STORE_DEPTH) begin
                  mem_ctl.we = 1'b1;
                  count_nxt  = cnt_e + CW'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
              if (do_bs && cnt_e != '0) begin
                count_nxt = cnt_dec;
                if (cnt_dec != '0) begin
                  mem_ctl.re = 1'b1;
                  rd_addr    = cnt_dec[AW-1:0];
                  state_nxt  = S_BS;
                end
              end
            end
            OP_FINISH: begin
              esc_nxt     = ES_GROUND;
              fin_nxt     = 1'b1;
              res_len_nxt = len_sat;
              res_ovf_nxt = ovf_r;
              res_ok_nxt  = 1'b0;
              state_nxt   = S_RES;
            end
            OP_READ: begin
              mem_ctl.re  = 1'b1;
              res_len_nxt = len_sat;
              res_ovf_nxt = ovf_r;
              res_ok_nxt  = idx_ok;
              state_nxt   = S_RES;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_BS: begin
        // back over utf-8 continuation bytes one entry per cycle
        if (rd_data[7:6] == UTF8_CONT_TAG) begin
          count_nxt = bs_prev;
          if (bs_prev != '0) begin
            mem_ctl.re = 1'b1;
            rd_addr    = bs_prev[AW-1:0];
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = res_len_r;
          out_ovf_nxt   = res_ovf_r;
          out_ok_nxt    = res_ok_r;
          out_byte_nxt  = res_ok_r ? rd_data : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      esc_r       <= ES_GROUND;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      esc_r       <= esc_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_len_r  <= out_len_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_byte_r <= out_byte_nxt;
    out_ok_r   <= out_ok_nxt;
    res_len_r  <= res_len_nxt;
    res_ovf_r  <= res_ovf_nxt;
    res_ok_r   <= res_ok_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.text_length = out_len_r;
  assign out_ch.overflowed  = out_ovf_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.index_ok    = out_ok_r;

  `TCC_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_r) <= STORE_DEPTH, "count beyond store")
  `TCC_ASSERT_NOW(a_bs_nonzero, state_r == S_BS, count_r != '0, "backspace walk at zero")
  `TCC_ASSERT_NOW(a_ovf_full, $rose(ovf_r), 32'(count_r) == STORE_DEPTH, "overflow below full")
  `TCC_ASSERT_NEXT(a_write_grow, mem_ctl.we, 32'(count_r) == 32'($past(wr_addr)) + 1, "count not past write")
  `TCC_ASSERT_NOW(a_res_quiet, state_r == S_RES, !mem_ctl.re && !mem_ctl.we, "store touched while result pending")

endmodule

`default_nettype wire

// ===== sv/terminal_text_cleaner_unit.sv =====
// terminal text cleaner: takes raw terminal bytes (op push), strips ansi csi/osc/two-byte
// escapes and control bytes other than lf and tab, applies backspace as removal of the last
// utf-8 code point, and keeps the plain text in an on-chip byte store of STORE_DEPTH entries.
// op finish returns the length and the sticky overflow flag; op read returns the byte at
// read_index with index_ok. a push does at most one store write; a read does a store read,
// finish none, and both then load the output register once it is free; a backspace that
// removes the only byte of the text does no store read, any other does one per byte it inspects:
// the removed byte, then the byte behind it for as long as the last one read was a utf-8
// continuation byte, stopping early when the walk reaches the start of the text.
// results are registered, so a result may wait on out_ch while pushes continue. the store has
// no clearing pass: a read at or beyond the current length returns a zero byte with index_ok
// low. lengths above 8191 saturate in text_length.
`default_nettype none

module terminal_text_cleaner_unit #(
  parameter int STORE_DEPTH = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tcc_in_if.sink      in_ch,
  tcc_out_if.source   out_ch
);
  import tcc_pkg::*;

  // address width of the store and width of the byte count (holds the full depth)
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  // store strobes and addresses from the controller
  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // escape parser, count, backspace walk and result register
  tcc_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // cleaned text, one write and one registered read per cycle
  tcc_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// ===== sim/terminal_text_cleaner_unit_test.sv =====
`default_nettype none

module terminal_text_cleaner_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int STORE_DEPTH  = 4096;
  localparam int RANDOM_ITEMS = 1750;
  localparam int IDLE_PCT     = 9;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ROWS         = 25;

  // op code the block has no use for
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one result beat as the block reports it
  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic              ovf;
    logic [BYTE_W-1:0] data;
    logic              ok;
  } text_reply_t;

  // one row of the directed table; want is used only where given is set
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    logic              given;
    text_reply_t       want;
  } step_row_t;

  // kinds of fragment a well-formed stretch of terminal output is built from
  typedef enum int {
    SEG_PLAIN, SEG_UTF8, SEG_ERASE, SEG_CSI, SEG_OSC,
    SEG_SHORT_ESC, SEG_WHITE, SEG_JUNK, SEG_PEEK
  } piece_t;

  logic clk = 1'b0;
  logic rst_n;

  tcc_in_if  in_ch();
  tcc_out_if out_ch();

  terminal_text_cleaner_unit #(
    .STORE_DEPTH(STORE_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted copy of the cleaned text and the parser
  logic [BYTE_W-1:0] plain_text [STORE_DEPTH];
  int unsigned       kept_count;
  esc_t              parse_state;
  logic              lost_bytes;
  logic              closed;

  text_reply_t replies_due [$];

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned beats_in;
  int unsigned counted_beats;
  int unsigned results_checked;
  int unsigned texts_done;
  int unsigned overflow_texts;
  int unsigned erasures;
  bit          steady;

  // directed table: reset state, field extremes, every op and the parser corner cases
  step_row_t directed_rows [ROWS] = '{
    '{OP_READ,   8'h00,    12'd0,        1'b1, '0},  // read straight after reset
    '{OP_FINISH, 8'h00,    12'd0,        1'b1, '0},  // finish an empty text
    '{OP_PUSH,   CH_BS,    12'd0,        1'b0, '0},  // new text, backspace on nothing
    '{OP_PUSH,   8'hFF,    12'd0,        1'b0, '0},  // top byte value, kept
    '{OP_PUSH,   8'h00,    12'd0,        1'b0, '0},  // nul, dropped
    '{OP_PUSH,   CH_DEL,   12'd0,        1'b0, '0},  // del, dropped
    '{OP_PUSH,   CH_TAB,   12'd0,        1'b0, '0},
    '{OP_PUSH,   8'hC3,    12'd0,        1'b0, '0},  // two-byte code point
    '{OP_PUSH,   8'hA9,    12'd0,        1'b0, '0},
    '{OP_PUSH,   CH_BS,    12'd0,        1'b0, '0},  // backs over the continuation byte
    '{OP_PUSH,   CH_ESC,   12'd0,        1'b0, '0},
    '{OP_PUSH,   CH_ESC,   12'd0,        1'b0, '0},  // esc esc is a whole sequence
    '{OP_PUSH,   CH_LF,    12'd0,        1'b0, '0},
    '{OP_PUSH,   CH_ESC,   12'd0,        1'b0, '0},
    '{OP_PUSH,   CH_RBRK,  12'd0,        1'b0, '0},  // osc open
    '{OP_PUSH,   CH_ESC,   12'd0,        1'b0, '0},
    '{OP_PUSH,   8'h62,    12'd0,        1'b0, '0},  // esc in osc without backslash
    '{OP_PUSH,   CH_BEL,   12'd0,        1'b0, '0},  // bel closes osc
    '{OP_PUSH,   CH_ESC,   12'd0,        1'b0, '0},
    '{OP_PUSH,   CH_LBRK,  12'd0,        1'b0, '0},  // csi open
    '{OP_PUSH,   8'h31,    12'd0,        1'b0, '0},  // parameter byte, csi stays open
    '{OP_FINISH, 8'h00,    12'd0,        1'b0, '0},  // finish closes the open csi
    '{OP_READ,   8'h00,    12'd0,        1'b0, '0},
    '{OP_UNUSED, 8'hFF,    {IDX_W{1'b1}}, 1'b0, '0}, // ignored, no result
    '{OP_READ,   8'h00,    {IDX_W{1'b1}}, 1'b0, '0}  // far past the text
  };

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic logic [LEN_W-1:0] length_now();
    return (kept_count > LEN_MAX) ? LEN_MAX : LEN_W'(kept_count);
  endfunction

  function automatic void keep_char(input logic [BYTE_W-1:0] b);
    if (kept_count < STORE_DEPTH) begin
      plain_text[IDX_W'(kept_count)] = b;
      kept_count++;
    end else begin
      lost_bytes = 1'b1;
    end
  endfunction

  // drop the last code point, walking back over continuation bytes
  function automatic void erase_code_point();
    if (kept_count == 0) return;
    kept_count--;
    while (kept_count > 0 && kept_count < STORE_DEPTH &&
           plain_text[IDX_W'(kept_count)][7:6] == UTF8_CONT_TAG)
      kept_count--;
  endfunction

  function automatic void parse_byte(input logic [BYTE_W-1:0] b);
    case (parse_state)
      ES_ESC: begin
        if (b == CH_LBRK)      parse_state = ES_CSI;
        else if (b == CH_RBRK) parse_state = ES_OSC;
        else                   parse_state = ES_GROUND;
      end
      ES_CSI: begin
        if (b >= CSI_LO && b <= CSI_HI) parse_state = ES_GROUND;
      end
      ES_OSC, ES_OSC_ESC: begin
        if (b == CH_BEL)                                  parse_state = ES_GROUND;
        else if (parse_state == ES_OSC_ESC && b == CH_BSLSH) parse_state = ES_GROUND;
        else if (b == CH_ESC)                             parse_state = ES_OSC_ESC;
        else                                              parse_state = ES_OSC;
      end
      default: begin
        parse_state = ES_GROUND;
        if (b == CH_ESC)                  parse_state = ES_ESC;
        else if (b == CH_BS)              erase_code_point();
        else if (b == CH_LF || b == CH_TAB) keep_char(b);
        else if (b >= CH_SPACE && b != CH_DEL) keep_char(b);
      end
    endcase
  endfunction

  // update the predicted state for one accepted beat and queue what it answers
  function automatic void predict_beat(input logic [OP_W-1:0] op,
                                       input logic [BYTE_W-1:0] b,
                                       input logic [IDX_W-1:0] idx,
                                       input logic given,
                                       input text_reply_t want);
    text_reply_t r;
    logic        answers;
    r       = '0;
    answers = 1'b0;
    case (op)
      OP_PUSH: begin
        // first byte after a finish opens a fresh text
        if (closed) begin
          kept_count  = 0;
          lost_bytes  = 1'b0;
          closed      = 1'b0;
          parse_state = ES_GROUND;
        end
        if (b == CH_BS) erasures++;
        parse_byte(b);
      end
      OP_FINISH: begin
        parse_state = ES_GROUND;
        closed      = 1'b1;
        r.length    = length_now();
        r.ovf       = lost_bytes;
        answers     = 1'b1;
        texts_done++;
        if (lost_bytes) overflow_texts++;
      end
      OP_READ: begin
        r.length = length_now();
        r.ovf    = lost_bytes;
        if (idx < kept_count) begin
          r.data = plain_text[idx];
          r.ok   = 1'b1;
        end
        answers = 1'b1;
      end
      default: ;
    endcase
    if (answers) replies_due.push_back(given ? want : r);
  endfunction

  // ---------------------------------------------------------------------
  // input side: one beat per call, held until the block takes it
  // ---------------------------------------------------------------------

  task automatic offer_beat(input logic [OP_W-1:0] op,
                            input logic [BYTE_W-1:0] b = '0,
                            input logic [IDX_W-1:0] idx = '0,
                            input logic given = 1'b0,
                            input text_reply_t want = '0);
    @(negedge clk);
    // random gaps before the beat, none during the steady stretch
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.in_byte    <= b;
    in_ch.read_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    beats_in++;
    if (op != OP_UNUSED) counted_beats++;
    predict_beat(op, b, idx, given, want);
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    offer_beat(OP_PUSH, b, IDX_W'($urandom_range(0, STORE_DEPTH - 1)));
  endtask

  task automatic read_at(input logic [IDX_W-1:0] idx);
    offer_beat(OP_READ, BYTE_W'($urandom_range(0, 255)), idx);
  endtask

  // mostly indexes inside the text, now and then anywhere
  task automatic read_somewhere();
    if (kept_count > 0 && $urandom_range(0, 9) < 8)
      read_at(IDX_W'($urandom_range(0, kept_count - 1)));
    else
      read_at(IDX_W'($urandom_range(0, STORE_DEPTH - 1)));
  endtask

  // fill the store to the brim, overrun it, then check the edges
  task automatic fill_store();
    logic [BYTE_W-1:0] b;
    repeat (STORE_DEPTH + 4) begin
      b = BYTE_W'($urandom_range(CH_SPACE, 8'hFE));
      if (b == CH_DEL) b = CH_SPACE;
      push_byte(b);
    end
    read_at(IDX_W'(STORE_DEPTH - 1));
    push_byte(CH_BS);
    read_at({IDX_W{1'b1}});
    read_somewhere();
    offer_beat(OP_FINISH);
    read_at(IDX_W'(STORE_DEPTH - 2));
    // a new text must clear the sticky overflow
    push_byte(8'h71);
    offer_beat(OP_FINISH);
  endtask

  // a stretch of terminal output built from well-formed fragments
  task automatic send_session();
    int unsigned       pieces;
    int unsigned       n;
    logic [BYTE_W-1:0] b;
    pieces = $urandom_range(1, 12);
    repeat (pieces) begin
      case (piece_t'($urandom_range(0, SEG_PEEK)))
        SEG_PLAIN: begin
          repeat ($urandom_range(1, 8))
            push_byte(BYTE_W'($urandom_range(CH_SPACE, CH_DEL - 1)));
        end
        SEG_UTF8: begin
          n = $urandom_range(2, 4);
          case (n)
            2:       b = 8'hC0 | BYTE_W'($urandom_range(0, 31));
            3:       b = 8'hE0 | BYTE_W'($urandom_range(0, 15));
            default: b = 8'hF0 | BYTE_W'($urandom_range(0, 7));
          endcase
          // now and then a stray run of continuation bytes with no lead
          if ($urandom_range(0, 4) == 0) b = 8'h80 | BYTE_W'($urandom_range(0, 63));
          push_byte(b);
          repeat (n - 1) push_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
        end
        SEG_ERASE: begin
          repeat ($urandom_range(1, 3)) push_byte(CH_BS);
        end
        SEG_CSI: begin
          push_byte(CH_ESC);
          push_byte(CH_LBRK);
          repeat ($urandom_range(0, 4))
            push_byte(BYTE_W'($urandom_range(CH_SPACE, CSI_LO - 1)));
          push_byte(BYTE_W'($urandom_range(CSI_LO, CSI_HI)));
        end
        SEG_OSC: begin
          push_byte(CH_ESC);
          push_byte(CH_RBRK);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 7) == 0) push_byte(CH_ESC);
            push_byte(BYTE_W'($urandom_range(CH_SPACE, CH_DEL - 1)));
          end
          if ($urandom_range(0, 1) == 0) begin
            push_byte(CH_BEL);
          end else begin
            push_byte(CH_ESC);
            push_byte(CH_BSLSH);
          end
        end
        SEG_SHORT_ESC: begin
          push_byte(CH_ESC);
          push_byte(($urandom_range(0, 5) == 0) ? CH_ESC
                                                : BYTE_W'($urandom_range(CSI_LO, 8'h5A)));
        end
        SEG_WHITE: begin
          push_byte(($urandom_range(0, 1) == 0) ? CH_LF : CH_TAB);
        end
        SEG_JUNK: begin
          push_byte(($urandom_range(0, 3) == 0) ? CH_DEL
                                                : BYTE_W'($urandom_range(0, CH_SPACE - 1)));
        end
        default: begin
          read_somewhere();
        end
      endcase
    end
    if ($urandom_range(0, 9) != 0) begin
      offer_beat(OP_FINISH, BYTE_W'($urandom_range(0, 255)),
                 IDX_W'($urandom_range(0, STORE_DEPTH - 1)));
      repeat ($urandom_range(0, 5)) read_somewhere();
    end
  endtask

  // raw noise: any op, any byte, any index
  task automatic send_noise();
    repeat ($urandom_range(1, 16))
      offer_beat(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                 IDX_W'($urandom_range(0, STORE_DEPTH - 1)));
  endtask

  // ---------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------

  // back-pressure on results, off during the steady stretch
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic void report_mismatch(input string what, input text_reply_t want,
                                          input text_reply_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch, %s, cycle %0d: expected len %0d ovf %0b byte %02h ok %0b, ",
                "%s %0d %0b %02h %0b"},
               what, cycles, want.length, want.ovf, want.data, want.ok,
               "got", got.length, got.ovf, got.data, got.ok);
  endfunction

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    text_reply_t got;
    text_reply_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.text_length, out_ch.overflowed, out_ch.out_byte, out_ch.index_ok};
      if (replies_due.size() == 0) begin
        report_mismatch("result with nothing due", '0, got);
      end else begin
        want = replies_due.pop_front();
        results_checked++;
        if (got.length !== want.length || got.ovf !== want.ovf ||
            got.data !== want.data || got.ok !== want.ok)
          report_mismatch("field differs", want, got);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, replies_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin : run
    int unsigned rand_start;
    int unsigned done;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_PUSH;
    in_ch.in_byte    = '0;
    in_ch.read_index = '0;
    out_ch.ready     = 1'b0;
    kept_count       = 0;
    parse_state      = ES_GROUND;
    lost_bytes       = 1'b0;
    closed           = 1'b0;
    steady           = 1'b0;
    cycles           = 0;
    mismatches       = 0;
    beats_in         = 0;
    counted_beats    = 0;
    results_checked  = 0;
    texts_done       = 0;
    overflow_texts   = 0;
    erasures         = 0;
    foreach (plain_text[i]) plain_text[i] = '0;

    // synchronous reset, released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_beat(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].idx,
                 directed_rows[i].given, directed_rows[i].want);

    fill_store();

    // random part: mostly well-formed output, some noise, one steady stretch
    rand_start = counted_beats;
    done       = 0;
    while (done < RANDOM_ITEMS) begin
      steady = (done >= 600 && done < 900);
      if ($urandom_range(0, 9) < 8) send_session();
      else                          send_noise();
      done = counted_beats - rand_start;
    end
    steady = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // let every outstanding result arrive, then idle before the final check
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (replies_due.size() != 0) begin
      mismatches++;
      $display("%0d predicted results never came out", replies_due.size());
    end

    $display("covered %0d input beats, %0d results checked, %0d texts closed",
             beats_in, results_checked, texts_done);
    $display("%0d texts overran the store, %0d backspaces, %0d mismatches",
             overflow_texts, erasures, mismatches);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
